FILE: rtl/vsm_pkg.sv
// Package for the vector softmax unit: sizes, table of 2^(-i/16), controller states.
// Used by the top level, controller, datapath and divider; no dependencies.
package vsm_pkg;
  localparam int unsigned MaxChannels = 64;
  localparam int unsigned IdxW = $clog2(MaxChannels);
  localparam int unsigned CntW = 7;
  localparam int unsigned ExpW = 17;
  localparam int unsigned SumW = 40;
  localparam int unsigned DivW = 41;

  typedef enum logic [5:0] {
    StLoad  = 6'b000001,
    StExpRd = 6'b000010,
    StExp   = 6'b000100,
    StOutRd = 6'b001000,
    StDiv   = 6'b010000,
    StOut   = 6'b100000
  } state_e;

  typedef struct packed {
    logic load;
    logic clr;
    logic exp_rd;
    logic exp_wr;
    logic out_rd;
    logic div_start;
    logic [IdxW-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic exp_done;
    logic div_done;
  } sts_t;

  function automatic logic [16:0] pow2_tab(input logic [4:0] i);
    logic [16:0] r;
    unique case (i)
      5'd0: r = 17'd65536;  5'd1: r = 17'd62757;  5'd2: r = 17'd60097;
      5'd3: r = 17'd57549;  5'd4: r = 17'd55109;  5'd5: r = 17'd52773;
      5'd6: r = 17'd50535;  5'd7: r = 17'd48393;  5'd8: r = 17'd46341;
      5'd9: r = 17'd44376;  5'd10: r = 17'd42495; 5'd11: r = 17'd40693;
      5'd12: r = 17'd38968; 5'd13: r = 17'd37316; 5'd14: r = 17'd35734;
      5'd15: r = 17'd34219; default: r = 17'd32768;
    endcase
    return r;
  endfunction
endpackage

FILE: rtl/vsm_in_if.sv
// Input channel: valid/ready with one element and its channel weight.
// Depends on nothing.
interface vsm_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] value;
  logic signed [15:0] channel_weight;
  modport source (output valid, value, channel_weight, input ready);
  modport sink (input valid, value, channel_weight, output ready);
endinterface

FILE: rtl/vsm_out_if.sv
// Output channel: valid/ready with one probability and its flags.
// Depends on nothing.
interface vsm_out_if;
  logic valid;
  logic ready;
  logic [15:0] probability;
  logic last;
  logic bad_sum;
  modport source (output valid, probability, last, bad_sum, input ready);
  modport sink (input valid, probability, last, bad_sum, output ready);
endinterface

FILE: rtl/vector_softmax_unit.sv
// Vector softmax unit: top level joining controller and datapath.
// Depends on vsm_pkg, vsm_in_if, vsm_out_if, vsm_ctrl, vsm_datapath.
// Elements transfer one per cycle into RAM while the maximum is tracked; no input is
// taken again until the last result of the vector has transferred. After the last
// element an exponent sweep runs; then each result takes an exponent read, a division
// in the bit-serial divider at one quotient bit per cycle, and a transfer that waits
// for ready.
module vector_softmax_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [vsm_pkg::CntW-1:0] cfg_wdata_i,
  vsm_in_if.sink                  in_if,
  vsm_out_if.source               out_if
);
  import vsm_pkg::*;
  logic [CntW-1:0] count_q;
  cmd_t cmd;
  sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) count_q <= CntW'(MaxChannels);
    else if (cfg_we_i) count_q <= cfg_wdata_i;
  end

  vsm_ctrl u_ctrl (
    .clk_i, .rst_ni, .count_i(count_q), .in_valid_i(in_if.valid),
    .in_ready_o(in_if.ready), .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready), .last_o(out_if.last), .cmd_o(cmd), .sts_i(sts));

  vsm_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .value_i(in_if.value),
    .weight_i(in_if.channel_weight), .probability_o(out_if.probability),
    .bad_sum_o(out_if.bad_sum));
endmodule

FILE: rtl/vsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module vsm_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: rtl/vsm_div.sv
// Restoring radix-2 divider: probability = min(65535, (e*2^24 + s/2) / s).
// Depends on vsm_pkg. One quotient bit per cycle over an 82-bit numerator; done_o is raised
// after the last bit.
module vsm_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [vsm_pkg::ExpW-1:0]      e_i,
  input  logic [vsm_pkg::SumW-1:0]      sum_i,
  output logic                          done_o,
  output logic [15:0]                   quot_o
);
  import vsm_pkg::*;
  // Only the low 18 quotient bits are kept; a one that shifts past bit 17 marks
  // saturation.
  logic [DivW+ExpW+24-1:0] num_q, num_d;
  logic [SumW-1:0] den_q;
  logic [DivW:0]   rem_q, rem_d;
  logic [17:0]     quo_q, quo_d;
  logic [6:0]      cnt_q;
  logic            busy_q, sat_q;
  logic [DivW:0]   trial;
  logic [DivW+ExpW+24-1:0] num0;

  logic [ExpW+24:0] full_num;
  assign full_num = {1'b0, e_i, 24'd0} + {2'b0, sum_i[SumW-1:1]};
  assign num0 = {{(DivW-1){1'b0}}, full_num};
  assign trial = {rem_q[DivW-1:0], num_q[DivW+ExpW+24-1]} - {2'b0, den_q};

  always_comb begin
    rem_d = {rem_q[DivW-1:0], num_q[DivW+ExpW+24-1]};
    quo_d = {quo_q[16:0], 1'b0};
    if (!trial[DivW]) begin
      rem_d = trial;
      quo_d[0] = 1'b1;
    end
    num_d = {num_q[DivW+ExpW+24-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
      sat_q  <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'(DivW + ExpW + 24);
        sat_q  <= 1'b0;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (quo_q[16] && !trial[DivW]) sat_q <= 1'b1;
        if (quo_q[17]) sat_q <= 1'b1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num0;
      den_q <= sum_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quot_o = (sat_q || quo_q[17] || quo_q[16]) ? 16'hFFFF : quo_q[15:0];
endmodule

FILE: rtl/vsm_datapath.sv
// Datapath: element stores, running max, exponent pipeline, weighted sum, divider.
// Depends on vsm_pkg, vsm_ram and vsm_div.
module vsm_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vsm_pkg::cmd_t       cmd_i,
  output vsm_pkg::sts_t       sts_o,
  input  logic signed [15:0]  value_i,
  input  logic signed [15:0]  weight_i,
  output logic [15:0]         probability_o,
  output logic                bad_sum_o
);
  import vsm_pkg::*;
  logic [15:0] val_rd, wgt_rd;
  logic [ExpW-1:0] exp_rd;
  logic signed [15:0] max_q;
  logic signed [SumW-1:0] sum_q;
  logic [IdxW-1:0] widx_q;
  logic            wr_q;

  vsm_ram #(.Width(16), .Depth(MaxChannels)) u_val (
    .clk_i, .we_i(cmd_i.load), .waddr_i(cmd_i.idx), .wdata_i(value_i),
    .raddr_i(cmd_i.idx), .rdata_o(val_rd));
  vsm_ram #(.Width(16), .Depth(MaxChannels)) u_wgt (
    .clk_i, .we_i(cmd_i.load), .waddr_i(cmd_i.idx), .wdata_i(weight_i),
    .raddr_i(cmd_i.idx), .rdata_o(wgt_rd));

  // Exponent pipeline, registered in order: product, clamp, log2(e) scale, table
  // interpolate, shift, then accumulate and write back.
  logic signed [32:0] x1_q;
  logic signed [15:0] w1_q, w2_q, w3_q, w4_q, w5_q;
  logic [IdxW-1:0] i0_q, i1_q, i2_q, i3_q, i4_q;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic [20:0] a2_q;
  logic [37:0] t2;
  logic [21:0] t3_q;
  logic [16:0] v4;
  logic [ExpW-1:0] e4_q, e_d;
  logic [16:0] tk, tk1;
  logic [16:0] dif;
  logic [29:0] prod;

  always_comb begin
    t2 = ({17'd0, a2_q} * 38'd94548 + 38'd32768) >> 16;
    tk = pow2_tab({1'b0, t3_q[15:12]});
    tk1 = pow2_tab({1'b0, t3_q[15:12]} + 5'd1);
    dif = tk - tk1;
    prod = {13'd0, dif} * {18'd0, t3_q[11:0]} + 30'd2048;
    v4 = tk - 17'(prod >> 12);
  end

  logic [16:0] m4_q;
  logic [5:0]  n4_q;
  always_comb begin
    if (n4_q >= 6'd17) e_d = '0;
    else if (n4_q == 6'd0) e_d = m4_q;
    else e_d = ExpW'(({1'b0, m4_q} + (18'd1 << (n4_q - 6'd1))) >> n4_q);
  end

  logic signed [33:0] ew;
  assign ew = $signed({1'b0, e4_q}) * w5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q, wr_q} <= '0;
      max_q <= 16'sh8000;
      sum_q <= '0;
    end else begin
      v1_q <= cmd_i.exp_rd;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      wr_q <= v5_q;
      if (cmd_i.load && value_i > max_q) max_q <= value_i;
      if (wr_q) sum_q <= sum_q + SumW'(ew);
      if (cmd_i.clr) begin
        max_q <= 16'sh8000;
        sum_q <= '0;
      end
    end
  end

  logic signed [33:0] x_full;
  assign x_full = $signed({val_rd, 8'd0}) - $signed(wgt_rd) * max_q;

  always_ff @(posedge clk_i) begin
    i0_q <= cmd_i.idx;
    x1_q <= x_full[32:0];
    w1_q <= wgt_rd;
    i1_q <= i0_q;
    if (x1_q > 0) a2_q <= '0;
    else if (x1_q < -33'sd1048576) a2_q <= 21'd1048576;
    else a2_q <= 21'(-x1_q);
    w2_q <= w1_q; i2_q <= i1_q;
    t3_q <= t2[21:0];
    w3_q <= w2_q; i3_q <= i2_q;
    m4_q <= v4;
    n4_q <= {t3_q[21:16] > 6'd17} ? 6'd17 : t3_q[21:16];
    w4_q <= w3_q; i4_q <= i3_q;
    e4_q <= e_d;
    w5_q <= w4_q;
    widx_q <= i4_q;
  end

  vsm_ram #(.Width(ExpW), .Depth(MaxChannels)) u_exp (
    .clk_i, .we_i(wr_q), .waddr_i(widx_q), .wdata_i(e4_q),
    .raddr_i(cmd_i.idx), .rdata_o(exp_rd));

  assign bad_sum_o = (sum_q <= 0);

  logic [15:0] quot;
  logic        div_done;
  vsm_div u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .e_i(exp_rd),
    .sum_i(sum_q), .done_o(div_done), .quot_o(quot));
  assign sts_o = '{exp_done: wr_q & ~v5_q, div_done: div_done};
  assign probability_o = bad_sum_o ? 16'd0 : quot;
  logic unused;
  assign unused = cmd_i.exp_wr ^ cmd_i.out_rd;
endmodule

FILE: rtl/vsm_ctrl.sv
// Controller: load, exponent sweep, divide-and-emit sequence per vector.
// Depends on vsm_pkg.
module vsm_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [vsm_pkg::CntW-1:0]     count_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         last_o,
  output vsm_pkg::cmd_t                cmd_o,
  input  vsm_pkg::sts_t                sts_i
);
  import vsm_pkg::*;
  state_e st_q, st_d;
  logic [CntW-1:0] cnt_q, cnt_d, i_q, i_d, neff;
  logic ov_q, ov_d;

  assign neff = (count_i == '0) ? CntW'(1) :
                (count_i > CntW'(MaxChannels)) ? CntW'(MaxChannels) : count_i;

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; i_d = i_q; ov_d = ov_q;
    cmd_o = '0;
    cmd_o.idx = i_q[IdxW-1:0];
    in_ready_o = 1'b0;
    unique case (st_q)
      StLoad: begin
        in_ready_o = 1'b1;
        cmd_o.idx = cnt_q[IdxW-1:0];
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d = cnt_q + CntW'(1);
          if (cnt_q + CntW'(1) >= neff) begin
            st_d = StExpRd; i_d = '0;
          end
        end
      end
      StExpRd: begin
        cmd_o.exp_rd = 1'b1;
        i_d = i_q + CntW'(1);
        if (i_q + CntW'(1) == cnt_q) st_d = StExp;
      end
      StExp: if (sts_i.exp_done) begin
        st_d = StOutRd; i_d = '0;
      end
      StOutRd: begin
        cmd_o.out_rd = 1'b1;
        st_d = StDiv;
      end
      StDiv: begin
        if (ov_q == 1'b0) begin
          cmd_o.div_start = 1'b1;
          ov_d = 1'b1;
        end
        if (sts_i.div_done) st_d = StOut;
      end
      StOut: if (out_ready_i) begin
        ov_d = 1'b0;
        i_d = i_q + CntW'(1);
        if (i_q + CntW'(1) == cnt_q) begin
          st_d = StLoad; cnt_d = '0; cmd_o.clr = 1'b1;
        end else st_d = StOutRd;
      end
      default: st_d = StLoad;
    endcase
  end

  assign out_valid_o = (st_q == StOut);
  assign last_o = (i_q + CntW'(1) == cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StLoad; cnt_q <= '0; i_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; i_q <= i_d; ov_q <= ov_d;
    end
  end

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(st_q))
    else $error("state not one-hot");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxChannels)) else $error("count overflow");
  a_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
endmodule
